### sv/double_ended_queue_macros.svh
// ---------------------------------------------------------------------------
// double_ended_queue_macros
// assertion helpers shared by the deque checker
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, sampled on the rising clock, quiet in reset
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, quiet in reset
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/dq_pkg.sv
// ---------------------------------------------------------------------------
// dq_pkg
// operation codes, status codes, beat types and fsm states of the deque
// ---------------------------------------------------------------------------
package dq_pkg;

   localparam int DATA_W  = 32;
   localparam int KIND_W  = 3;
   localparam int COUNT_W = 11;
   localparam int STAT_W  = 2;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] taken_value;
      logic [STAT_W-1:0]        status;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } state_type;

endpackage

### sv/double_ended_queue.sv
// ---------------------------------------------------------------------------
// double_ended_queue
// bounded deque of signed 32-bit values in a ring buffer
// ---------------------------------------------------------------------------
// Each request beat is one operation (push front, push back, pop front,
// pop back or query; unused codes act as a query) and gives exactly one
// response beat with the popped value, a status, the count afterwards, an
// empty flag and the front and back entries afterwards (zero when empty).
// Entries live in a single-port-write, single-port-read ram of DEPTH words;
// the two end values are also kept in registers, so pushes, queries and
// pops that leave at most one entry finish in 1 cycle. A pop that leaves
// two or more entries takes 2 cycles: the new end value has to be read
// from the ram, whose read data arrives one cycle after the address. The
// response sits in an output register; a new request is taken in the same
// cycle the previous response is taken, but not while a response is held
// stalled. No clearing pass is needed after reset: only held entries are
// ever read.
// ---------------------------------------------------------------------------
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int AW = $clog2(DEPTH);       // ring index width
   localparam int CW = $clog2(DEPTH + 1);   // count width, holds DEPTH itself

   // ring index arithmetic: base < DEPTH and off <= DEPTH, one fold suffices
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // control state
   state_type                state_ff, state_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // payload state
   logic signed [DATA_W-1:0] front_ff, front_in;
   logic signed [DATA_W-1:0] back_ff, back_in;
   logic                     fill_front_ff, fill_front_in;
   rsp_type                  rsp_ff, rsp_in;

   // ram ports
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic signed [DATA_W-1:0] rd_data;

   logic                     accept;
   logic                     rsp_take;
   logic                     full;
   logic                     empty;

   dq_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_dq_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // busy while the new end is fetched, or while a response waits stalled
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      logic signed [DATA_W-1:0] taken;
      logic [STAT_W-1:0]        status;
      logic                     fetch;

      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      fill_front_in = fill_front_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_take ? 1'b0 : rsp_valid_ff;

      wr_en   = 1'b0;
      wr_addr = head_ff;
      wr_data = req_payload.value;
      rd_en   = 1'b0;
      rd_addr = head_ff;

      taken  = '0;
      status = STATUS_OK;
      fetch  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_payload.kind)
                  KIND_PUSH_FRONT: begin
                     if (full) begin
                        status = STATUS_FULL;
                     end else begin
                        head_in  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
                        wr_en    = 1'b1;
                        wr_addr  = head_in;
                        front_in = req_payload.value;
                        if (empty) begin
                           back_in = req_payload.value;
                        end
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_PUSH_BACK: begin
                     if (full) begin
                        status = STATUS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = wrap_add(head_ff, count_ff);
                        back_in = req_payload.value;
                        if (empty) begin
                           front_in = req_payload.value;
                        end
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_POP_FRONT: begin
                     if (empty) begin
                        status = STATUS_EMPTY;
                     end else begin
                        taken    = front_ff;
                        head_in  = wrap_add(head_ff, CW'(1));
                        count_in = count_ff - 1'b1;
                        // one left: it is the back entry; more: read it
                        if (count_in == CW'(1)) begin
                           front_in = back_ff;
                        end else if (count_in != '0) begin
                           fetch         = 1'b1;
                           fill_front_in = 1'b1;
                           rd_en         = 1'b1;
                           rd_addr       = head_in;
                        end
                     end
                  end
                  KIND_POP_BACK: begin
                     if (empty) begin
                        status = STATUS_EMPTY;
                     end else begin
                        taken    = back_ff;
                        count_in = count_ff - 1'b1;
                        if (count_in == CW'(1)) begin
                           back_in = front_ff;
                        end else if (count_in != '0) begin
                           fetch         = 1'b1;
                           fill_front_in = 1'b0;
                           rd_en         = 1'b1;
                           rd_addr       = wrap_add(head_ff, count_in - 1'b1);
                        end
                     end
                  end
                  default: begin
                     // query, and the unused codes
                     if (empty) begin
                        status = STATUS_EMPTY;
                     end
                  end
               endcase

               rsp_in.taken_value = taken;
               rsp_in.status      = status;
               rsp_in.count       = COUNT_W'(count_in);
               rsp_in.is_empty    = (count_in == '0);
               rsp_in.front_value = (count_in == '0) ? '0 : front_in;
               rsp_in.back_value  = (count_in == '0) ? '0 : back_in;

               if (fetch) begin
                  state_in = ST_FETCH;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            // ram data for the new end has arrived; count is at least two
            if (fill_front_ff) begin
               front_in = rd_data;
            end else begin
               back_in = rd_data;
            end
            rsp_in.front_value = front_in;
            rsp_in.back_value  = back_in;
            rsp_valid_in       = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, gated by count and valid so no reset needed
   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      back_ff       <= back_in;
      fill_front_ff <= fill_front_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### sv/dq_ram.sv
// ---------------------------------------------------------------------------
// dq_ram
// entry store: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module dq_ram
   import dq_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = $signed(rd_data_ff);

endmodule

### sv/dq_checker.sv
// ---------------------------------------------------------------------------
// dq_checker
// port-level checks of the deque response beats
// ---------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module dq_checker
   import dq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   `DQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_payload),
      "stalled response beat changed")

   `DQ_ASSERT_NOW(a_empty_zero, rsp_valid && rsp_payload.is_empty,
      (rsp_payload.count == '0) && (rsp_payload.front_value == '0)
         && (rsp_payload.back_value == '0),
      "empty deque reports entries")

   `DQ_ASSERT_NOW(a_full_refused, rsp_valid && (rsp_payload.status == STATUS_FULL),
      !rsp_payload.is_empty && (rsp_payload.taken_value == '0),
      "refused push reports a value or an empty deque")

   `DQ_ASSERT_NOW(a_empty_status, rsp_valid && (rsp_payload.status == STATUS_EMPTY),
      rsp_payload.is_empty && (rsp_payload.taken_value == '0),
      "empty status on a non-empty deque")

endmodule

bind double_ended_queue dq_checker u_dq_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
